FILE: sv/mmc_pkg.sv
// shared types, constants and arithmetic helpers for the model matrix composer
`default_nettype none
package mmc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int ANG_FRAC        = ANGLE_BITS - 3;

  localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [31:0] ONE_COORD   = 32'sd1 <<< COORD_FRAC_BITS;

  // one queued update command between front and back
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic               set_pos;
    logic               set_rot;
    logic               set_scale;
  } cmd_t;

  // one result column
  typedef struct packed {
    logic               which_matrix;
    logic [1:0]         column;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last;
  } col_t;

  // add half, arithmetic shift (floor) of a Q60 product to Q30
  function automatic logic signed [35:0] rnd30(input logic signed [71:0] p);
    logic signed [71:0] v;
    v = p + 72'sd536870912;
    return 36'(v >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

endpackage
`default_nettype wire

FILE: sv/mmc_front.sv
// front part: accepts update items, sign-extends angles, feeds a two-entry queue
`default_nettype none
module mmc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire mmc_pkg::cmd_t in_cmd,
  output logic              q_valid,
  input  wire logic         q_take,
  output mmc_pkg::cmd_t     q_cmd
);
  import mmc_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  cmd_t       norm;
  logic       do_push, do_pop;

  function automatic logic signed [15:0] sx_ang(input logic signed [15:0] a);
    return 16'($signed(a[ANGLE_BITS-1:0]));
  endfunction

  always_comb begin
    norm = in_cmd;
    norm.rot_x = sx_ang(in_cmd.rot_x);
    norm.rot_y = sx_ang(in_cmd.rot_y);
    norm.rot_z = sx_ang(in_cmd.rot_z);
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= norm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

FILE: sv/mmc_back.sv
// back part: state update, sin/cos and matrix sequencer over one shared multiplier
`default_nettype none
module mmc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_take,
  input  wire mmc_pkg::cmd_t q_cmd,
  output logic               o_valid,
  input  wire logic          o_take,
  output mmc_pkg::col_t      o_col
);
  import mmc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_ANG = 4'd1, S_X2 = 4'd2, S_SPOLY = 4'd3,
                         S_SFIN = 4'd4, S_CPOLY = 4'd5, S_ROT = 4'd6, S_ELEM = 4'd7,
                         S_EMIT = 4'd8;

  logic [3:0] state;
  logic signed [31:0] cpos [3], cscl [3], opos [3], oscl [3];
  logic signed [15:0] crot [3], orot [3];

  logic        mat;        // 0 current, 1 old
  logic [1:0]  ai;         // angle index
  logic [2:0]  k;          // poly step
  logic        ph;         // 0 series product, 1 reciprocal multiply
  logic [3:0]  ri;         // rotation product step
  logic [1:0]  col;
  logic [1:0]  row;
  logic signed [35:0] x, x2, t;
  logic        neg;
  logic signed [35:0] dv;
  logic        dneg;
  logic signed [35:0] sn [3], cs [3];
  logic signed [35:0] sxsy, cxsy, rm [3][3];
  logic signed [35:0] pa, pb;
  logic signed [71:0] prod;
  logic signed [35:0] pr;
  logic [5:0]         rsh;
  logic signed [35:0] quo, sq;
  logic signed [31:0] elem [3];

  logic signed [15:0] ang_sel;
  logic signed [31:0] scl_sel;
  logic signed [31:0] pos_sel [3];

  // reciprocal of each series divisor d, ceil(2^s / d) with s = 32 + ceil(log2 d)
  function automatic logic signed [35:0] recip(input logic [2:0] i, input logic cosp);
    if (cosp) begin
      case (i)
        3'd0: return 36'sd8329633544;
        3'd1: return 36'sd6108397933;
        3'd2: return 36'sd4908534053;
        3'd3: return 36'sd4581298450;
        3'd4: return 36'sd5726623062;
        default: return 36'sd4294967296;
      endcase
    end else begin
      case (i)
        3'd0: return 36'sd4997780127;
        3'd1: return 36'sd7635497416;
        3'd2: return 36'sd6544712071;
        3'd3: return 36'sd6871947674;
        default: return 36'sd5726623062;
      endcase
    end
  endfunction

  function automatic logic [5:0] rshift(input logic [2:0] i, input logic cosp);
    if (cosp) begin
      case (i)
        3'd0: return 6'd40;
        3'd1: return 6'd39;
        3'd2: return 6'd38;
        3'd3: return 6'd37;
        3'd4: return 6'd36;
        default: return 6'd33;
      endcase
    end else begin
      case (i)
        3'd0: return 6'd39;
        3'd1: return 6'd39;
        3'd2: return 6'd38;
        3'd3: return 6'd37;
        default: return 6'd35;
      endcase
    end
  endfunction

  assign prod = pa * pb;   // one multiplier, registered result use only
  assign pr   = rnd30(prod);

  // exact truncating divide of a magnitude below 2^32 by the series divisor
  assign rsh = rshift(k, state == S_CPOLY);
  assign quo = 36'(prod >>> rsh);
  assign sq  = dneg ? -quo : quo;

  always_comb begin
    ang_sel = mat ? orot[ai] : crot[ai];
    scl_sel = mat ? oscl[col] : cscl[col];
    for (int i = 0; i < 3; i++) pos_sel[i] = mat ? opos[i] : cpos[i];
  end

  // multiplier operand selection
  always_comb begin
    pa = x2;
    pb = t;
    unique case (state)
      S_X2:   begin pa = x;  pb = x;  end
      S_SPOLY: if (ph) begin pa = dv; pb = recip(k, 1'b0); end
      S_SFIN: begin pa = x;  pb = t;  end
      S_CPOLY: if (ph) begin pa = dv; pb = recip(k, 1'b1); end
      S_ROT: begin
        unique case (ri)
          4'd0: begin pa = sn[0]; pb = sn[1]; end
          4'd1: begin pa = cs[0]; pb = sn[1]; end
          4'd2: begin pa = cs[1]; pb = cs[2]; end
          4'd3: begin pa = cs[1]; pb = sn[2]; end
          4'd4: begin pa = sxsy;  pb = cs[2]; end
          4'd5: begin pa = cs[0]; pb = sn[2]; end
          4'd6: begin pa = cs[0]; pb = cs[2]; end
          4'd7: begin pa = sxsy;  pb = sn[2]; end
          4'd8: begin pa = sn[0]; pb = cs[1]; end
          4'd9: begin pa = sn[0]; pb = sn[2]; end
          4'd10: begin pa = cxsy; pb = cs[2]; end
          4'd11: begin pa = cxsy; pb = sn[2]; end
          4'd12: begin pa = sn[0]; pb = cs[2]; end
          default: begin pa = cs[0]; pb = cs[1]; end
        endcase
      end
      S_ELEM: begin pa = rm[row][col]; pb = 36'(scl_sel); end
      default: ;
    endcase
  end

  assign q_take  = (state == S_IDLE) && q_valid;
  assign o_valid = (state == S_EMIT);

  always_comb begin
    o_col.which_matrix = mat;
    o_col.column = col;
    o_col.last = mat && (col == 2'd3);
    if (col == 2'd3) begin
      o_col.elem_0 = pos_sel[0];
      o_col.elem_1 = pos_sel[1];
      o_col.elem_2 = pos_sel[2];
      o_col.elem_3 = ONE_COORD;
    end else begin
      o_col.elem_0 = elem[0];
      o_col.elem_1 = elem[1];
      o_col.elem_2 = elem[2];
      o_col.elem_3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        cpos[i] <= '0; opos[i] <= '0;
        crot[i] <= '0; orot[i] <= '0;
        cscl[i] <= ONE_COORD; oscl[i] <= ONE_COORD;
      end
      mat <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          if (q_cmd.set_pos) begin
            opos <= cpos;
            cpos[0] <= q_cmd.pos_x; cpos[1] <= q_cmd.pos_y; cpos[2] <= q_cmd.pos_z;
          end
          if (q_cmd.set_rot) begin
            orot <= crot;
            crot[0] <= q_cmd.rot_x; crot[1] <= q_cmd.rot_y; crot[2] <= q_cmd.rot_z;
          end
          if (q_cmd.set_scale) begin
            oscl <= cscl;
            cscl[0] <= q_cmd.scale_x; cscl[1] <= q_cmd.scale_y; cscl[2] <= q_cmd.scale_z;
          end
          mat <= 1'b0;
          ai <= 2'd0;
          state <= S_ANG;
        end
        S_ANG: begin
          // widen to q30 and fold into [-pi/2, pi/2]
          logic signed [35:0] w;
          w = 36'(ang_sel) <<< (30 - ANG_FRAC);
          if (w > Q30_HALF_PI) begin x <= w - Q30_PI; neg <= 1'b1; end
          else if (w < -Q30_HALF_PI) begin x <= w + Q30_PI; neg <= 1'b1; end
          else begin x <= w; neg <= 1'b0; end
          state <= S_X2;
        end
        S_X2: begin
          x2 <= pr; t <= Q30_ONE; k <= 3'd0; ph <= 1'b0; state <= S_SPOLY;
        end
        S_SPOLY: begin
          if (!ph) begin
            dv <= pr[35] ? -pr : pr; dneg <= pr[35]; ph <= 1'b1;
          end else begin
            t <= Q30_ONE - sq;
            ph <= 1'b0;
            if (k == 3'd4) state <= S_SFIN;
            else k <= k + 3'd1;
          end
        end
        S_SFIN: begin
          sn[ai] <= neg ? -pr : pr;
          t <= Q30_ONE; k <= 3'd0; ph <= 1'b0; state <= S_CPOLY;
        end
        S_CPOLY: begin
          if (!ph) begin
            dv <= pr[35] ? -pr : pr; dneg <= pr[35]; ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (k == 3'd5) begin
              cs[ai] <= neg ? sq - Q30_ONE : Q30_ONE - sq;
              if (ai == 2'd2) begin ri <= 4'd0; state <= S_ROT; end
              else begin ai <= ai + 2'd1; state <= S_ANG; end
            end else begin
              t <= Q30_ONE - sq;
              k <= k + 3'd1;
            end
          end
        end
        S_ROT: begin
          unique case (ri)
            4'd0: sxsy <= pr;
            4'd1: cxsy <= pr;
            4'd2: rm[0][0] <= pr;
            4'd3: begin rm[0][1] <= -pr; rm[0][2] <= sn[1]; end
            4'd4: rm[1][0] <= pr;
            4'd5: rm[1][0] <= rm[1][0] + pr;
            4'd6: rm[1][1] <= pr;
            4'd7: rm[1][1] <= rm[1][1] - pr;
            4'd8: rm[1][2] <= -pr;
            4'd9: rm[2][0] <= pr;
            4'd10: rm[2][0] <= rm[2][0] - pr;
            4'd11: rm[2][1] <= pr;
            4'd12: rm[2][1] <= rm[2][1] + pr;
            default: rm[2][2] <= pr;
          endcase
          if (ri == 4'd13) begin
            col <= 2'd0; row <= 2'd0; state <= S_ELEM;
          end else ri <= ri + 4'd1;
        end
        S_ELEM: begin
          elem[row] <= sat32(pr);
          if (row == 2'd2) state <= S_EMIT;
          else row <= row + 2'd1;
        end
        S_EMIT: if (o_take) begin
          if (col == 2'd3) begin
            if (mat) state <= S_IDLE;
            else begin mat <= 1'b1; ai <= 2'd0; state <= S_ANG; end
          end else if (col == 2'd2) begin
            col <= 2'd3;
          end else begin
            col <= col + 2'd1; row <= 2'd0; state <= S_ELEM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/mmc_outq.sv
// result queue: two-entry fifo that parts the sequencer from the consumer
`default_nettype none
module mmc_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          i_valid,
  output logic               i_take,
  input  wire mmc_pkg::col_t i_col,
  output logic               empty,
  input  wire logic          pop,
  output mmc_pkg::col_t      o_col
);
  import mmc_pkg::*;

  col_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_pop;

  assign i_take = i_valid && (count != 2'd2);
  assign empty  = (count == 2'd0);
  assign o_col  = mem[rp];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (i_take) mem[wp] <= i_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (i_take) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + 2'(i_take) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

FILE: sv/model_matrix_compose_core.sv
// top level of the model matrix composer
// channel   dir  handshake      payload
// input     in   push / full    pos_*, rot_*, scale_*, set_*
// result    out  empty / pop    which_matrix, column, elem_0..3, last
// each item gives eight column transactions, current matrix then old matrix
// the back part takes a new item only after both matrices of the last one are emitted;
// all its work runs on the single shared 36x36 multiplier: six angles (series terms
// take two passes, the second a reciprocal multiply), 14 rotation products and the
// scaling and emitting of each matrix
// rst is synchronous; it restores identity state and empties both queues
// a two-entry queue in front and behind lets each side stall on its own
`default_nettype none
module model_matrix_compose_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [15:0] rot_x,
  input  wire logic [15:0] rot_y,
  input  wire logic [15:0] rot_z,
  input  wire logic [31:0] scale_x,
  input  wire logic [31:0] scale_y,
  input  wire logic [31:0] scale_z,
  input  wire logic        set_pos,
  input  wire logic        set_rot,
  input  wire logic        set_scale,
  output logic             empty,
  input  wire logic        pop,
  output logic             which_matrix,
  output logic [1:0]       column,
  output logic [31:0]      elem_0,
  output logic [31:0]      elem_1,
  output logic [31:0]      elem_2,
  output logic [31:0]      elem_3,
  output logic             last
);
  import mmc_pkg::*;

  cmd_t in_cmd, q_cmd;
  col_t b_col, o_col;
  logic q_valid, q_take, b_valid, b_take;

  always_comb begin
    in_cmd.pos_x = pos_x; in_cmd.pos_y = pos_y; in_cmd.pos_z = pos_z;
    in_cmd.rot_x = rot_x; in_cmd.rot_y = rot_y; in_cmd.rot_z = rot_z;
    in_cmd.scale_x = scale_x; in_cmd.scale_y = scale_y; in_cmd.scale_z = scale_z;
    in_cmd.set_pos = set_pos; in_cmd.set_rot = set_rot; in_cmd.set_scale = set_scale;
  end

  mmc_front u_front (.clk, .rst, .push, .full, .in_cmd,
                     .q_valid, .q_take, .q_cmd);
  mmc_back u_back (.clk, .rst, .q_valid, .q_take, .q_cmd,
                   .o_valid(b_valid), .o_take(b_take), .o_col(b_col));
  mmc_outq u_outq (.clk, .rst, .i_valid(b_valid), .i_take(b_take), .i_col(b_col),
                   .empty, .pop, .o_col);

  assign which_matrix = o_col.which_matrix;
  assign column = o_col.column;
  assign elem_0 = o_col.elem_0;
  assign elem_1 = o_col.elem_1;
  assign elem_2 = o_col.elem_2;
  assign elem_3 = o_col.elem_3;
  assign last = o_col.last;
endmodule
`default_nettype wire

FILE: sv/mmc_checker.sv
// port-level checks for the model matrix composer, bound to the top level
`default_nettype none
module mmc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       which_matrix,
  input wire logic [1:0] column,
  input wire logic [31:0] elem_3,
  input wire logic       last
);
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (which_matrix && column == 2'd3)))
    else $error("last flag mismatch");
  a_row3: assert property (@(posedge clk) disable iff (rst)
    (!empty && column == 2'd3) |-> (elem_3 == 32'h00010000))
    else $error("column 3 row 3 not one");
  a_row3z: assert property (@(posedge clk) disable iff (rst)
    (!empty && column != 2'd3) |-> (elem_3 == 32'h0))
    else $error("row 3 not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(column) && $stable(which_matrix)))
    else $error("waiting transaction changed");
  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("not empty after reset");
endmodule

bind model_matrix_compose_core mmc_checker u_mmc_checker (.clk, .rst, .empty, .pop,
  .which_matrix, .column, .elem_3, .last);
`default_nettype wire

FILE: test/model_matrix_compose_core_tb.sv
// self-checking testbench for the model matrix composer core
`timescale 1ns / 1ps
module model_matrix_compose_core_tb;
  import mmc_pkg::*;

  typedef struct {
    cmd_t cmd;
    bit   drain;
  } pend_t;
  typedef longint mat_t[4][4];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  cmd_t drv = '0;
  logic which_matrix, last;
  logic [1:0] column;
  logic [31:0] elem_0, elem_1, elem_2, elem_3;

  pend_t  pending[$];
  col_t   expected_cols[$];
  longint cur_pos[3], cur_rot[3], cur_scl[3], old_pos[3], old_rot[3], old_scl[3];
  int     errors = 0;
  int     items_sent = 0;
  int     cols_seen = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  bit     held_long = 0;

  model_matrix_compose_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(drv.pos_x), .pos_y(drv.pos_y), .pos_z(drv.pos_z),
    .rot_x(drv.rot_x), .rot_y(drv.rot_y), .rot_z(drv.rot_z),
    .scale_x(drv.scale_x), .scale_y(drv.scale_y), .scale_z(drv.scale_z),
    .set_pos(drv.set_pos), .set_rot(drv.set_rot), .set_scale(drv.set_scale),
    .empty(empty), .pop(pop), .which_matrix(which_matrix), .column(column),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q60 to Q30 with half added, floor shift
  function automatic longint q30_round(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sin_cos_q30(longint ang, output longint sn, output longint cs);
    longint sk[5] = '{110, 72, 42, 20, 6};
    longint ck[6] = '{132, 90, 56, 30, 12, 2};
    longint x, x2, t;
    bit flip;
    x = ang * (64'sd1 <<< (30 - ANG_FRAC));
    flip = 0;
    if (x > Q30_HALF_PI) begin
      x -= Q30_PI;
      flip = 1;
    end else if (x < -Q30_HALF_PI) begin
      x += Q30_PI;
      flip = 1;
    end
    x2 = q30_round(x * x);
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - q30_round(x2 * t) / sk[i];
    sn = q30_round(x * t);
    t = Q30_ONE;
    for (int i = 0; i < 6; i++) t = Q30_ONE - q30_round(x2 * t) / ck[i];
    cs = t;
    if (flip) begin
      sn = -sn;
      cs = -cs;
    end
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void model_matrix(longint p[3], longint r[3], longint s[3],
                                       output mat_t m);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint rm[3][3];
    sin_cos_q30(r[0], sx, cx);
    sin_cos_q30(r[1], sy, cy);
    sin_cos_q30(r[2], sz, cz);
    sxsy = q30_round(sx * sy);
    cxsy = q30_round(cx * sy);
    rm[0][0] = q30_round(cy * cz);
    rm[0][1] = -q30_round(cy * sz);
    rm[0][2] = sy;
    rm[1][0] = q30_round(sxsy * cz) + q30_round(cx * sz);
    rm[1][1] = q30_round(cx * cz) - q30_round(sxsy * sz);
    rm[1][2] = -q30_round(sx * cy);
    rm[2][0] = q30_round(sx * sz) - q30_round(cxsy * cz);
    rm[2][1] = q30_round(cxsy * sz) + q30_round(sx * cz);
    rm[2][2] = q30_round(cx * cy);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[i][j] = clip32(q30_round(rm[i][j] * s[j]));
      m[i][3] = p[i];
      m[3][i] = 0;
    end
    m[3][3] = 64'sd1 <<< COORD_FRAC_BITS;
  endfunction

  // update pose state and queue the eight expected columns
  function automatic void predict_columns(cmd_t c);
    mat_t mats[2];
    col_t e;
    if (c.set_pos) begin
      old_pos = cur_pos;
      cur_pos = '{longint'(c.pos_x), longint'(c.pos_y), longint'(c.pos_z)};
    end
    if (c.set_rot) begin
      old_rot = cur_rot;
      cur_rot = '{longint'(c.rot_x), longint'(c.rot_y), longint'(c.rot_z)};
    end
    if (c.set_scale) begin
      old_scl = cur_scl;
      cur_scl = '{longint'(c.scale_x), longint'(c.scale_y), longint'(c.scale_z)};
    end
    model_matrix(cur_pos, cur_rot, cur_scl, mats[0]);
    model_matrix(old_pos, old_rot, old_scl, mats[1]);
    for (int k = 0; k < 8; k++) begin
      e.which_matrix = k[2];
      e.column = k[1:0];
      e.elem_0 = 32'(mats[k >> 2][0][k & 3]);
      e.elem_1 = 32'(mats[k >> 2][1][k & 3]);
      e.elem_2 = 32'(mats[k >> 2][2][k & 3]);
      e.elem_3 = 32'(mats[k >> 2][3][k & 3]);
      e.last = (k == 7);
      expected_cols.push_back(e);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] coord_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'(ONE_COORD);
      4: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] angle_val();
    // about pi/2 in Q3.13 is 12868
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0;
      3: return 16'(12866 + $urandom_range(0, 4));
      4: return 16'(-12870 + $urandom_range(0, 4));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.pos_x = coord_val();
    c.pos_y = coord_val();
    c.pos_z = coord_val();
    c.rot_x = angle_val();
    c.rot_y = angle_val();
    c.rot_z = angle_val();
    c.scale_x = coord_val();
    c.scale_y = coord_val();
    c.scale_z = coord_val();
    c.set_pos = $urandom_range(0, 1);
    c.set_rot = $urandom_range(0, 1);
    c.set_scale = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic void add_cmd(logic [31:0] p, logic [15:0] a, logic [31:0] s,
                                  logic [2:0] sets, bit drain = 0);
    pend_t pd;
    pd.cmd = '{p, -p, p ^ 32'h5a5a5a5a, a, -a, a ^ 16'h0f0f, s, -s, s ^ 32'h00ff0000,
               sets[2], sets[1], sets[0]};
    pd.drain = drain;
    pending.push_back(pd);
  endfunction

  // sender
  always @(posedge clk) begin
    cmd_t nxt;
    logic nxt_push;
    nxt = drv;
    nxt_push = push;
    if (rst) begin
      nxt_push = 0;
    end else begin
      if (push && !full) begin
        predict_columns(drv);
        items_sent++;
        nxt_push = 0;
        send_gap = pick_gap();
      end
      if (!nxt_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && expected_cols.size() > 0)) begin
          nxt = pending.pop_front().cmd;
          nxt_push = 1;
        end
      end
    end
    drv <= nxt;
    push <= nxt_push;
  end

  // receiver and checker
  always @(posedge clk) begin
    col_t e;
    logic nxt_pop;
    nxt_pop = pop;
    if (rst) begin
      nxt_pop = 0;
    end else begin
      if (pop && !empty) begin
        cols_seen++;
        if (expected_cols.size() == 0) begin
          $display("%0t: unexpected column transaction wm=%0d col=%0d",
                   $time, which_matrix, column);
          errors++;
        end else begin
          e = expected_cols.pop_front();
          if ({which_matrix, column, elem_0, elem_1, elem_2, elem_3, last} !== e) begin
            $display("%0t: mismatch expected wm=%0d col=%0d %h %h %h %h last=%0d",
                     $time, e.which_matrix, e.column, e.elem_0, e.elem_1, e.elem_2,
                     e.elem_3, e.last);
            $display("%0t:          actual wm=%0d col=%0d %h %h %h %h last=%0d",
                     $time, which_matrix, column, elem_0, elem_1, elem_2, elem_3, last);
            errors++;
          end
        end
        nxt_pop = 0;
        // one long hold-off so the input side backs up
        if (!held_long && cols_seen == 400) begin
          held_long = 1;
          recv_gap = 4000;
        end else begin
          recv_gap = pick_gap();
        end
      end
      if (!nxt_pop) begin
        if (recv_gap > 0) recv_gap--;
        else nxt_pop = 1;
      end
    end
    pop <= nxt_pop;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      cur_pos[i] = 0;
      old_pos[i] = 0;
      cur_rot[i] = 0;
      old_rot[i] = 0;
      cur_scl[i] = ONE_COORD;
      old_scl[i] = ONE_COORD;
    end
    // directed: identity, extremes, quadrant edges, zero/negative scale, saturation
    add_cmd(32'h0, 16'h0, 32'(ONE_COORD), 3'b000);
    add_cmd(32'h0001_8000, 16'h0, 32'(ONE_COORD), 3'b111);
    add_cmd(32'h7fffffff, 16'h7fff, 32'h7fffffff, 3'b111);
    add_cmd(32'h80000000, 16'h8000, 32'h80000000, 3'b111);
    add_cmd(32'h0, 16'd12868, 32'h0, 3'b010);
    add_cmd(32'h0, 16'd12869, 32'h0, 3'b011);
    add_cmd(32'h0, -16'sd12869, 32'hffff0000, 3'b011);
    add_cmd(32'h0, -16'sd12868, 32'h7fffffff, 3'b011);
    add_cmd(32'h1234_5678, 16'h0, 32'h0000_0000, 3'b100);
    add_cmd(32'h0, 16'h1000, 32'h8000_0000, 3'b001);
    add_cmd(32'hffffffff, 16'hffff, 32'hffffffff, 3'b111);
    add_cmd(32'h0, 16'h0, 32'h0, 3'b010);
    add_cmd(32'h0, 16'h0, 32'h0, 3'b010, 1);
    add_cmd(32'h5555_5555, 16'h2aaa, 32'h0002_0000, 3'b101);
    add_cmd(32'haaaa_aaaa, 16'hd555, 32'hfffe_0000, 3'b111);
    add_cmd(32'h0, 16'h6487, 32'h7fffffff, 3'b110);
    for (int n = 0; n < 415; n++) begin
      pend_t pd;
      pd.cmd = random_cmd();
      pd.drain = (n == 200);
      pending.push_back(pd);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !push);
    wait (expected_cols.size() == 0);
    repeat (600) @(posedge clk);
    $display("run covered %0d update transactions and %0d column transactions,",
             items_sent, cols_seen);
    $display("with extreme poses, quadrant-edge angles and output back-pressure");
    if (errors == 0 && expected_cols.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
